>>> design/d16e_pkg.sv
// Package: shared types, constants and codes of the delta-16 escape index encoder.
`default_nettype none
package d16e_pkg;

	localparam int unsigned COL_W       = 20;
	localparam int unsigned COL_BITS_DEF = 20;
	localparam int unsigned PREV_W      = COL_W + 1;
	localparam int unsigned GAP_W       = COL_W + 1;
	localparam int unsigned WORD_W      = 16;
	localparam int unsigned VALUE_W     = 32;

	localparam logic [WORD_W-1:0] ESCAPE_WORD = 16'hFFFF;

	// cmd field codes
	localparam logic CMD_BEGIN_ROW = 1'b0;
	localparam logic CMD_COLUMN    = 1'b1;

	// kind field codes
	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_OFFSET = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ESC_ZERO,
		ST_NEXT
	} d16e_state_t;

	// controller to datapath
	typedef struct packed {
		logic row_begin;  // begin-row request taken
		logic col_take;   // sparse column request taken
		logic esc_zero;   // emit second word of an escape pair
		logic next_word;  // emit next escape or final gap word
	} d16e_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;  // output register may be loaded this cycle
		logic skip;       // incoming column is dense
		logic new_big;    // incoming gap needs an escape
		logic held_big;   // held gap still needs an escape
	} d16e_status_t;

endpackage
`default_nettype wire

>>> design/d16e_if.sv
// Interfaces: request and result channels of the delta-16 escape index encoder.
`default_nettype none
interface d16e_in_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [d16e_pkg::COL_W-1:0] column;

	modport source (output valid, output cmd, output column, input ready);
	modport sink (input valid, input cmd, input column, output ready);
endinterface

interface d16e_out_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [d16e_pkg::VALUE_W-1:0] value;
	logic                         last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink (input valid, input kind, input value, input last, output ready);
endinterface
`default_nettype wire

>>> design/delta16_escape_index_encoder.sv
// Top level: delta-16 escape index encoder, controller plus datapath.
// Latency: a result is shown in the cycle after its request is taken.
// Words: one per begin-row or short gap request; a gap of g > 65535 takes
//   1 + 2*ceil((g - 65535) / 65535) words, one output register load per word.
// Dense columns are absorbed with no result; a new request waits until the last word is loaded.
// Reset (arst_n low) clears the state machine, dense limit, previous column and
//   stream length at once; no clearing pass is needed.
`default_nettype none
module delta16_escape_index_encoder #(
	parameter int unsigned COL_BITS = d16e_pkg::COL_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [d16e_pkg::COL_W-1:0] cfg_wdata,
	d16e_in_if.sink                         in_ch,
	d16e_out_if.source                      out_ch
);
	import d16e_pkg::*;

	d16e_cmd_t    dp_cmd;
	d16e_status_t dp_status;

	// sequence each request; hold the request side while a long gap unrolls
	d16e_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.cmd),
		.in_ready (in_ch.ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	// arithmetic, row state and the output register that parts the two sides
	d16e_dp #(
		.COL_BITS (COL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_column (in_ch.column),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_kind  (out_ch.kind),
		.out_value (out_ch.value),
		.out_last  (out_ch.last)
	);

`ifndef SYNTH
	// a stalled result blocks new requests
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready)
		else $error("request taken while result stalled");

	// an escape word is followed at once by its zero partner
	a_escape_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.kind == KIND_WORD &&
		out_ch.value == 32'h0000FFFF && !out_ch.last
		|=> out_ch.valid && out_ch.value == 32'd0 && !out_ch.last)
		else $error("escape word without zero partner");

	// begin row yields one offset result in the next cycle
	a_begin_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.cmd == CMD_BEGIN_ROW
		|=> out_ch.valid && out_ch.kind == KIND_OFFSET && out_ch.last)
		else $error("begin row gave no offset result");
`endif

endmodule
`default_nettype wire

>>> design/d16e_ctrl.sv
// Controller: sequences one request into its result words.
`default_nettype none
module d16e_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_cmd,
	output logic                        in_ready,
	input  wire d16e_pkg::d16e_status_t status,
	output d16e_pkg::d16e_cmd_t         cmd
);
	import d16e_pkg::*;

	d16e_state_t state_q;
	d16e_state_t state_next;
	logic        accept;

	assign in_ready = (state_q == ST_IDLE) && status.slot_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_cmd == CMD_COLUMN && !status.skip && status.new_big) begin
					state_next = ST_ESC_ZERO;
				end
			end
			ST_ESC_ZERO: begin
				if (status.slot_free) begin
					state_next = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (status.slot_free) begin
					state_next = status.held_big ? ST_ESC_ZERO : ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.row_begin = accept && (in_cmd == CMD_BEGIN_ROW);
				cmd.col_take  = accept && (in_cmd == CMD_COLUMN) && !status.skip;
			end
			ST_ESC_ZERO: begin
				cmd.esc_zero = status.slot_free;
			end
			ST_NEXT: begin
				cmd.next_word = status.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/d16e_dp.sv
// Datapath: gap arithmetic, row state, stream counter and output register.
`default_nettype none
module d16e_dp #(
	parameter int unsigned COL_BITS = d16e_pkg::COL_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [d16e_pkg::COL_W-1:0]   cfg_wdata,
	input  wire logic [d16e_pkg::COL_W-1:0]   in_column,
	input  wire d16e_pkg::d16e_cmd_t          cmd,
	output d16e_pkg::d16e_status_t            status,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic                              out_kind,
	output logic [d16e_pkg::VALUE_W-1:0]      out_value,
	output logic                              out_last
);
	import d16e_pkg::*;

	localparam logic [GAP_W-1:0] WRAP_MASK = (GAP_W'(1) << COL_BITS) - GAP_W'(1);
	localparam logic [GAP_W-1:0] ESC_GAP   = GAP_W'(ESCAPE_WORD);

	logic [COL_W-1:0]   dense_q;
	logic [PREV_W-1:0]  prev_q;
	logic [VALUE_W-1:0] stream_q;
	logic [GAP_W-1:0]   gap_q;
	logic               valid_q;
	logic               kind_q;
	logic [VALUE_W-1:0] value_q;
	logic               last_q;

	logic [GAP_W:0]     diff;
	logic [GAP_W-1:0]   new_gap;
	logic               held_big;
	logic               new_big;
	logic               load;

	// gap to previous column; wrap modulo 2^COL_BITS when it goes negative
	assign diff    = {2'b00, in_column} - {prev_q[PREV_W-1], prev_q};
	assign new_gap = diff[GAP_W] ? (diff[GAP_W-1:0] & WRAP_MASK) : diff[GAP_W-1:0];
	assign new_big  = |new_gap[GAP_W-1:WORD_W];
	assign held_big = |gap_q[GAP_W-1:WORD_W];

	assign status.slot_free = !valid_q || out_ready;
	assign status.skip      = in_column < dense_q;
	assign status.new_big   = new_big;
	assign status.held_big  = held_big;

	assign load = cmd.row_begin || cmd.col_take || cmd.esc_zero || cmd.next_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dense_q  <= '0;
			prev_q   <= '0;
			stream_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				dense_q <= cfg_wdata;
			end
			if (cmd.row_begin) begin
				prev_q <= {1'b0, dense_q} - PREV_W'(1);
			end
			if (cmd.col_take) begin
				prev_q <= {1'b0, in_column};
			end
			if (cmd.col_take || cmd.esc_zero || cmd.next_word) begin
				stream_q <= stream_q + VALUE_W'(1);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload and held gap
	always_ff @(posedge clk) begin
		if (cmd.row_begin) begin
			kind_q  <= KIND_OFFSET;
			value_q <= stream_q;
			last_q  <= 1'b1;
		end else if (cmd.col_take) begin
			gap_q   <= new_gap;
			kind_q  <= KIND_WORD;
			value_q <= new_big ? VALUE_W'(ESCAPE_WORD) : VALUE_W'(new_gap);
			last_q  <= !new_big;
		end else if (cmd.esc_zero) begin
			gap_q   <= gap_q - ESC_GAP;
			kind_q  <= KIND_WORD;
			value_q <= '0;
			last_q  <= 1'b0;
		end else if (cmd.next_word) begin
			kind_q  <= KIND_WORD;
			value_q <= held_big ? VALUE_W'(ESCAPE_WORD) : VALUE_W'(gap_q);
			last_q  <= !held_big;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_value = value_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench: delta-16 escape index encoder, driven with directed requests and random rows and checked word by word.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import d16e_pkg::*;

	// One result as the block shows it on its result channel.
	typedef struct packed {
		logic               kind;
		logic [VALUE_W-1:0] value;
		logic               last;
	} enc_word_t;

	localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [COL_W-1:0] cfg_wdata;

	d16e_in_if  req_ch ();
	d16e_out_if res_ch ();

	delta16_escape_index_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (req_ch),
		.out_ch    (res_ch)
	);

	always #5 clk = ~clk;

	// Predictor state: a private copy of the dense limit, the gap base and the
	// count of stream words emitted so far.
	logic [COL_W-1:0]        limit_m;
	logic signed [PREV_W-1:0] gap_base_m;
	logic [VALUE_W-1:0]      stream_len_m;

	// Words still owed by the block, oldest first.
	enc_word_t awaited_words[$];

	int unsigned mismatches = 0;
	int unsigned requests_sent = 0;

	// Idling controls: the test tasks switch them per phase.
	bit req_idle_on = 1'b0;
	bit res_idle_on = 1'b0;
	int unsigned res_hold_req = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// Append one owed word at the tail of the queue.
	function automatic void owe_word(input logic kind, input logic [VALUE_W-1:0] value,
			input logic last);
		enc_word_t w;
		w = '{kind, value, last};
		awaited_words.insert(awaited_words.size(), w);
	endfunction

	// Work out what one accepted request must produce and queue it.
	function automatic void encode_request(input logic cmd, input logic [COL_W-1:0] col);
		int          d;
		int unsigned gap;
		int unsigned n;
		n = 0;
		if (cmd == CMD_BEGIN_ROW) begin
			// Offset of the row, then restart the gap base just below the dense region.
			owe_word(KIND_OFFSET, stream_len_m, 1'b1);
			gap_base_m = {1'b0, limit_m} - 21'd1;
			return;
		end
		// Dense column: swallowed, no state change.
		if (col < limit_m)
			return;
		d = int'(col) - int'(gap_base_m);
		// Backward step wraps within the column width.
		gap = (d >= 0) ? d : (d & ((1 << COL_BITS_DEF) - 1));
		while (gap > 65535) begin
			owe_word(KIND_WORD, {16'h0, ESCAPE_WORD}, 1'b0);
			owe_word(KIND_WORD, 32'h0, 1'b0);
			gap -= 65535;
			n += 2;
		end
		owe_word(KIND_WORD, gap, 1'b1);
		n++;
		stream_len_m += n;
		gap_base_m = {1'b0, col};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
	endfunction

	// Offer one request, hold it until taken, then predict. Valid stays high
	// afterwards so back-to-back requests keep the channel busy.
	task automatic send_request(input logic cmd, input logic [COL_W-1:0] col);
		if (req_idle_on && $urandom_range(0, 2) == 0) begin
			req_ch.valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.cmd    <= cmd;
		req_ch.column <= col;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (cmd == CMD_BEGIN_ROW || col >= limit_m)
			requests_sent++;
		encode_request(cmd, col);
	endtask

	// Drop valid and wait for every owed word, then let a trailing dense
	// request settle.
	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Register write: only with the block drained.
	task automatic set_dense_limit(input logic [COL_W-1:0] lim);
		wait_all_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		limit_m = lim;
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 40);
		if (r < 85)
			return $urandom_range(41, 4000);
		if (r < 95)
			return $urandom_range(60000, 140000);
		return $urandom_range(140001, 1048575);
	endfunction

	// One well-formed row: begin-row request, then ascending sparse columns,
	// spiced with dense columns and the odd random column as noise.
	task automatic send_row(input int unsigned n_cols);
		longint unsigned col;
		longint unsigned nxt;
		int unsigned     r;
		send_request(CMD_BEGIN_ROW, COL_W'($urandom_range(0, COL_MAX)));
		col = 64'(limit_m);
		for (int i = 0; i < n_cols; i++) begin
			r = $urandom_range(0, 99);
			if (r < 6 && limit_m > 0) begin
				send_request(CMD_COLUMN, COL_W'($urandom_range(0, limit_m - 1)));
			end else if (r < 10) begin
				send_request(CMD_COLUMN, COL_W'($urandom_range(0, COL_MAX)));
			end else begin
				nxt = col + ((i == 0) ? $urandom_range(0, 3) : pick_step());
				if (nxt > COL_MAX)
					break;
				col = nxt;
				send_request(CMD_COLUMN, col[COL_W-1:0]);
			end
		end
	endtask

	// Result checker: compare every accepted word with the oldest expectation.
	always @(posedge clk) begin : check_results
		enc_word_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (awaited_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d value %0d last %0d",
					res_ch.kind, res_ch.value, res_ch.last));
			end else begin
				want = awaited_words.pop_front();
				if (res_ch.kind !== want.kind)
					report_mismatch($sformatf("kind expected %0d got %0d",
						want.kind, res_ch.kind));
				if (res_ch.value !== want.value)
					report_mismatch($sformatf("value expected %0d got %0d",
						want.value, res_ch.value));
				if (res_ch.last !== want.last)
					report_mismatch($sformatf("last expected %0d got %0d",
						want.last, res_ch.last));
			end
		end
	end

	// Result side: random stalls, plus long hold-offs on request, counted here.
	initial begin : drive_result_ready
		int unsigned stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_hold_req > 0) begin
				stall_left   = res_hold_req;
				res_hold_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (res_idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap() - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic pick_idling();
		req_idle_on = ($urandom_range(0, 3) != 0);
		res_idle_on = ($urandom_range(0, 3) != 0);
	endtask

	// Field extremes, escape boundaries, wrapping, dense skip and register
	// behaviour, one request at a time.
	task automatic test_directed();
		pick_idling();
		send_request(CMD_COLUMN, 20'd5);         // column before any row: base 0
		send_request(CMD_COLUMN, 20'd0);         // backward: wraps, full run of escapes
		send_request(CMD_BEGIN_ROW, COL_MAX);    // limit 0: base becomes -1
		send_request(CMD_COLUMN, COL_MAX);       // largest gap, most words
		send_request(CMD_COLUMN, COL_MAX);       // equal column, gap 0
		send_request(CMD_BEGIN_ROW, 20'd0);
		send_request(CMD_COLUMN, 20'd65534);     // gap 65535, just no escape
		send_request(CMD_COLUMN, 20'd131070);    // gap 65536, one escape
		send_request(CMD_BEGIN_ROW, 20'd0);
		send_request(CMD_COLUMN, 20'd0);
		set_dense_limit(20'h80000);             // base must not move
		send_request(CMD_COLUMN, 20'h7FFFF);     // dense
		send_request(CMD_COLUMN, 20'h80000);
		send_request(CMD_BEGIN_ROW, 20'h12345);
		send_request(CMD_COLUMN, 20'h80000);     // first sparse column, gap 1
		send_request(CMD_COLUMN, 20'd0);         // dense
		set_dense_limit(COL_MAX);
		send_request(CMD_COLUMN, 20'hFFFFE);
		send_request(CMD_BEGIN_ROW, 20'd0);
		send_request(CMD_COLUMN, COL_MAX);
		send_request(CMD_COLUMN, COL_MAX);
		set_dense_limit(20'd1);
		send_request(CMD_BEGIN_ROW, 20'd0);
		send_request(CMD_COLUMN, 20'd0);
		send_request(CMD_COLUMN, 20'd1);
	endtask

	// Random rows under one dense limit until the quota of live requests is met.
	task automatic test_random_rows(input logic [COL_W-1:0] lim, input int unsigned quota);
		int unsigned stop_at;
		set_dense_limit(lim);
		pick_idling();
		stop_at = requests_sent + quota;
		while (requests_sent < stop_at)
			send_row($urandom_range(1, 12));
	endtask

	// Hold the result side off for a long stretch while requests keep coming,
	// so the block fills up and stalls its input.
	task automatic test_backpressure();
		wait_all_results();
		req_idle_on  = 1'b0;
		res_idle_on  = 1'b0;
		res_hold_req = 400;
		send_request(CMD_BEGIN_ROW, 20'd0);
		for (int i = 0; i < 6; i++) begin
			send_request(CMD_COLUMN, COL_W'($urandom_range(0, COL_MAX)));
			send_request(CMD_COLUMN, COL_W'($urandom_range(0, COL_MAX)));
		end
		send_request(CMD_BEGIN_ROW, 20'd0);
	endtask

	// Pause the request side until everything owed has come, then resume.
	task automatic test_pause();
		pick_idling();
		send_row(6);
		wait_all_results();
		send_row(6);
		send_request(CMD_BEGIN_ROW, COL_W'($urandom_range(0, COL_MAX)));
	endtask

	initial begin : run_tests
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.cmd     <= CMD_BEGIN_ROW;
		req_ch.column  <= '0;
		limit_m         = '0;
		gap_base_m      = '0;
		stream_len_m    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_rows(20'd0, 90);
		test_random_rows(COL_W'($urandom_range(0, COL_MAX)), 60);
		test_random_rows(COL_W'($urandom_range(1, 255)), 80);
		test_random_rows(COL_MAX, 15);
		test_random_rows(COL_W'($urandom_range(20'h80000, 20'hFFFF0)), 40);
		test_backpressure();
		test_pause();
		test_random_rows(20'd0, 60);

		// Drain, give trailing work time to show, then settle the verdict.
		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaited_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Guard against a hang anywhere above.
	initial begin : watchdog
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
